/* rtl/core/jse_pkg.sv */
`timescale 1ns / 1ps

package jse_pkg;

   // Width of the running output byte count.
   localparam int LENGTH_BITS = 16;
   // Width of the length field of a result.
   localparam int LEN_FIELD_W = 16;
   // Width that holds count plus run length, or capacity, without overflow.
   localparam int CMP_W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = 2;

   typedef logic [LENGTH_BITS-1:0] count_type;
   typedef logic [LEN_FIELD_W-1:0] len_type;
   typedef logic [CMP_W-1:0]       cmp_type;
   typedef logic [15:0]            cap_type;
   typedef logic [2:0]             beat_type;
   typedef logic [Q_PTR_W-1:0]     qptr_type;
   typedef logic [Q_PTR_W:0]       qcnt_type;

   localparam cap_type CAPACITY_RESET = 16'hFFFF;

   // Characters that take part in the escape rules.
   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_BS     = 8'h08;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_FF     = 8'h0C;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_LOW_A  = 8'h61;
   localparam logic [7:0] CHR_LOW_B  = 8'h62;
   localparam logic [7:0] CHR_LOW_F  = 8'h66;
   localparam logic [7:0] CHR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHR_LOW_R  = 8'h72;
   localparam logic [7:0] CHR_LOW_T  = 8'h74;
   localparam logic [7:0] CHR_LOW_U  = 8'h75;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   // Run lengths of the three escape forms.
   localparam logic [2:0] RUN_LEN_PLAIN = 3'd1;
   localparam logic [2:0] RUN_LEN_SHORT = 3'd2;
   localparam logic [2:0] RUN_LEN_UNI   = 3'd6;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_SHORT,
      KIND_UNI,
      KIND_END
   } kind_type;

   // One queued run: what the back end has to emit.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] chr;
      count_type  base;
   } run_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = CHR_ZERO + {4'd0, nib};
      end else begin
         res = CHR_LOW_A + {4'd0, nib} - 8'd10;
      end
      return res;
   endfunction

endpackage

/* rtl/core/jse_if.sv */
`timescale 1ns / 1ps

interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface jse_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [7:0]              out_byte;
   logic                    is_end;
   logic                    last;
   logic [15:0]             length;
   modport source (output valid, output out_byte, output is_end, output last,
                   output length, input ready);
   modport sink (input valid, input out_byte, input is_end, input last,
                 input length, output ready);
endinterface

interface jse_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] capacity;
   modport source (output valid, output capacity, input ready);
   modport sink (input valid, input capacity, output ready);
endinterface

/* rtl/core/jse_queue.sv */
`timescale 1ns / 1ps

module jse_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  jse_pkg::run_type          push_data,
   input  logic                      pop,
   output jse_pkg::run_type          pop_data,
   output jse_pkg::queue_status_type status
);

   jse_pkg::run_type  mem_ff [jse_pkg::QUEUE_DEPTH];
   jse_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   jse_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   jse_pkg::qcnt_type cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + jse_pkg::qptr_type'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + jse_pkg::qptr_type'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + jse_pkg::qcnt_type'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - jse_pkg::qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (cnt_ff == jse_pkg::qcnt_type'(jse_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);

endmodule

/* rtl/core/jse_front.sv */
`timescale 1ns / 1ps

module jse_front (
   input  logic                      clock,
   input  logic                      reset,
   jse_req_if.sink                   req,
   jse_csr_if.sink                   csr,
   input  jse_pkg::queue_status_type q_status,
   output logic                      push,
   output jse_pkg::run_type          push_data
);

   jse_pkg::cap_type   capacity_ff;
   jse_pkg::count_type count_ff, count_in;
   logic               halted_ff, halted_in;

   jse_pkg::kind_type  kind;
   logic [7:0]         esc_chr;
   logic [2:0]         run_len;
   jse_pkg::cmp_type   sum;
   logic               accept;
   logic               is_nul;
   logic               fits;

   // Classify the byte into one of the escape forms.
   always_comb begin
      kind    = jse_pkg::KIND_PLAIN;
      esc_chr = req.in_byte;
      unique case (req.in_byte)
         jse_pkg::CHR_QUOTE:  kind = jse_pkg::KIND_SHORT;
         jse_pkg::CHR_BSLASH: kind = jse_pkg::KIND_SHORT;
         jse_pkg::CHR_LF: begin
            kind    = jse_pkg::KIND_SHORT;
            esc_chr = jse_pkg::CHR_LOW_N;
         end
         jse_pkg::CHR_CR: begin
            kind    = jse_pkg::KIND_SHORT;
            esc_chr = jse_pkg::CHR_LOW_R;
         end
         jse_pkg::CHR_TAB: begin
            kind    = jse_pkg::KIND_SHORT;
            esc_chr = jse_pkg::CHR_LOW_T;
         end
         jse_pkg::CHR_BS: begin
            kind    = jse_pkg::KIND_SHORT;
            esc_chr = jse_pkg::CHR_LOW_B;
         end
         jse_pkg::CHR_FF: begin
            kind    = jse_pkg::KIND_SHORT;
            esc_chr = jse_pkg::CHR_LOW_F;
         end
         default: begin
            if (req.in_byte < jse_pkg::CTRL_LIMIT) begin
               kind = jse_pkg::KIND_UNI;
            end
         end
      endcase
   end

   always_comb begin
      unique case (kind)
         jse_pkg::KIND_SHORT: run_len = jse_pkg::RUN_LEN_SHORT;
         jse_pkg::KIND_UNI:   run_len = jse_pkg::RUN_LEN_UNI;
         default:             run_len = jse_pkg::RUN_LEN_PLAIN;
      endcase
   end

   assign req.ready = !q_status.full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign is_nul    = (req.in_byte == jse_pkg::CHR_NUL);
   assign sum       = jse_pkg::cmp_type'(count_ff) + jse_pkg::cmp_type'(run_len);
   assign fits      = (sum < jse_pkg::cmp_type'(capacity_ff));

   assign push           = accept && (is_nul || (!halted_ff && fits));
   assign push_data.kind = is_nul ? jse_pkg::KIND_END : kind;
   assign push_data.chr  = esc_chr;
   assign push_data.base = count_ff;

   always_comb begin
      count_in  = count_ff;
      halted_in = halted_ff;
      if (accept) begin
         if (is_nul) begin
            count_in  = '0;
            halted_in = 1'b0;
         end else if (!halted_ff) begin
            if (fits) begin
               count_in = jse_pkg::count_type'(sum);
            end else begin
               halted_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= jse_pkg::CAPACITY_RESET;
         count_ff    <= '0;
         halted_ff   <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            capacity_ff <= csr.capacity;
         end
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

endmodule

/* rtl/core/jse_back.sv */
`timescale 1ns / 1ps

module jse_back (
   input  logic                      clock,
   input  logic                      reset,
   input  jse_pkg::run_type          run,
   input  jse_pkg::queue_status_type q_status,
   output logic                      pop,
   jse_rsp_if.source                 rsp
);

   jse_pkg::beat_type  beat_ff, beat_in;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic               is_end_ff, is_end_in;
   logic               last_ff, last_in;
   jse_pkg::len_type   length_ff, length_in;

   jse_pkg::beat_type  last_beat;
   jse_pkg::count_type len_sum;
   logic               can_load;
   logic               take;

   always_comb begin
      unique case (run.kind)
         jse_pkg::KIND_SHORT: last_beat = jse_pkg::RUN_LEN_SHORT - 3'd1;
         jse_pkg::KIND_UNI:   last_beat = jse_pkg::RUN_LEN_UNI - 3'd1;
         default:             last_beat = '0;
      endcase
   end

   assign can_load = !valid_ff || rsp.ready;
   assign take     = !q_status.empty && can_load;
   assign pop      = take && (beat_ff == last_beat);
   assign len_sum  = run.base + jse_pkg::count_type'(beat_ff) + jse_pkg::count_type'(1);

   // Byte of the current beat.
   always_comb begin
      byte_in = jse_pkg::CHR_BSLASH;
      unique case (run.kind)
         jse_pkg::KIND_PLAIN: byte_in = run.chr;
         jse_pkg::KIND_SHORT: begin
            if (beat_ff != '0) begin
               byte_in = run.chr;
            end
         end
         jse_pkg::KIND_UNI: begin
            case (beat_ff) inside
               3'd1:       byte_in = jse_pkg::CHR_LOW_U;
               3'd2, 3'd3: byte_in = jse_pkg::CHR_ZERO;
               3'd4:       byte_in = jse_pkg::hex_digit(run.chr[7:4]);
               3'd5:       byte_in = jse_pkg::hex_digit(run.chr[3:0]);
               default:    byte_in = jse_pkg::CHR_BSLASH;
            endcase
         end
         default: byte_in = jse_pkg::CHR_NUL;
      endcase
   end

   always_comb begin
      valid_in  = valid_ff;
      beat_in   = beat_ff;
      is_end_in = is_end_ff;
      last_in   = last_ff;
      length_in = length_ff;
      if (can_load) begin
         valid_in = !q_status.empty;
      end
      if (take) begin
         is_end_in = (run.kind == jse_pkg::KIND_END);
         last_in   = (beat_ff == last_beat);
         length_in = (run.kind == jse_pkg::KIND_END) ? jse_pkg::len_type'(run.base)
                                                      : jse_pkg::len_type'(len_sum);
         beat_in   = pop ? '0 : beat_ff + jse_pkg::beat_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= byte_in;
      end
      is_end_ff <= is_end_in;
      last_ff   <= last_in;
      length_ff <= length_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.is_end   = is_end_ff;
   assign rsp.last     = last_ff;
   assign rsp.length   = length_ff;

endmodule

/* rtl/core/json_string_escape.sv */
`timescale 1ns / 1ps
// An accepted byte is written into the run queue and from there into the back end's output register.
// Throughput: one output byte per cycle with the sink ready, set by the back end's single output
//   register; a pass-through byte is one byte, a short escape two and a \u00xx escape six.
// Input bytes are taken back to back while the four-entry run queue has room.
// Reset is synchronous and active high: count, halt flag, queue and output valid clear,
//   and capacity returns to 65535.

module json_string_escape (
   input  logic      clock,
   input  logic      reset,
   jse_req_if.sink   req_chan,
   jse_rsp_if.source rsp_chan,
   jse_csr_if.sink   csr_chan
);

   // The front end classifies each byte, checks whether its whole escape run
   // still fits below the capacity, and keeps the running output count and the
   // halt flag. Runs that fit while the string is not halted, and every
   // terminator, go into a short queue as one descriptor each: the escape form,
   // the character and the count before the run.
   logic                      q_push;
   logic                      q_pop;
   jse_pkg::run_type          q_push_data;
   jse_pkg::run_type          q_pop_data;
   jse_pkg::queue_status_type q_status;

   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr       (csr_chan),
      .q_status  (q_status),
      .push      (q_push),
      .push_data (q_push_data)
   );

   // The queue decouples the two sides, so that the front keeps taking bytes
   // while the back works through a multi-byte escape or waits on the sink.
   jse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // The back end walks each descriptor one output byte per cycle into its
   // output register while the sink is ready. It computes the running length
   // from the count stored with the run, so it never has to look at the front end's state.
   jse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .run      (q_pop_data),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp      (rsp_chan)
   );

   // The front end never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("run queue overflow");

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("run queue underflow");

   // An accepted terminator always leaves a descriptor in the queue.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.in_byte == jse_pkg::CHR_NUL))
      |=> !q_status.empty)
      else $error("terminator was not queued");

endmodule

/* sim/json_string_escape_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the streaming JSON string escaper.
// Source bytes go in on the request channel, escaped bytes and end-of-string
// transactions come back on the response channel, and the capacity register is
// written through the register channel only while the block is idle.
// A small scoreboard class predicts every response transaction from the bytes
// that were accepted and compares each one against what the block produces.
module json_string_escape_tb;

   localparam int CLK_HALF    = 10;
   localparam int RESET_TICKS = 11;
   // Cycles allowed to pass after the last expected transaction before a write.
   localparam int SETTLE      = 16;
   // Cycles in a row without any accepted transaction before the run is called hung.
   localparam int IDLE_LIMIT  = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_ITEMS = 16;
   localparam int NUM_PHASES  = 8;

   // One response transaction as the scoreboard sees it.
   typedef struct packed {
      logic [7:0]       out_byte;
      logic             is_end;
      logic             last;
      jse_pkg::len_type length;
   } escape_beat_type;

   // Predicts the escaped stream and holds the transactions still owed by the block.
   class escape_scoreboard;
      jse_pkg::cap_type   capacity;
      jse_pkg::count_type out_count;
      bit                 halted;
      escape_beat_type    owed_q[$];
      int                 mismatches;
      int                 bytes_seen;
      int                 beats_checked;
      int                 strings_ended;

      function new();
         capacity      = jse_pkg::CAPACITY_RESET;
         out_count     = '0;
         halted        = 1'b0;
         mismatches    = 0;
         bytes_seen    = 0;
         beats_checked = 0;
         strings_ended = 0;
      endfunction

      function void set_capacity(jse_pkg::cap_type value);
         capacity = value;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function logic [7:0] hex_char(logic [3:0] nib);
         if (nib < 4'd10) begin
            return jse_pkg::CHR_ZERO + {4'd0, nib};
         end
         return jse_pkg::CHR_LOW_A + ({4'd0, nib} - 8'd10);
      endfunction

      // Builds the escape sequence of one byte, first byte in the low bits,
      // and returns how many bytes it has.
      function int expand(logic [7:0] b, output logic [47:0] seq);
         logic [7:0] tail;
         seq = '0;
         case (b)
            jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH: tail = b;
            jse_pkg::CHR_LF:                         tail = jse_pkg::CHR_LOW_N;
            jse_pkg::CHR_CR:                         tail = jse_pkg::CHR_LOW_R;
            jse_pkg::CHR_TAB:                        tail = jse_pkg::CHR_LOW_T;
            jse_pkg::CHR_BS:                         tail = jse_pkg::CHR_LOW_B;
            jse_pkg::CHR_FF:                         tail = jse_pkg::CHR_LOW_F;
            default:                                 tail = jse_pkg::CHR_NUL;
         endcase
         if (tail != jse_pkg::CHR_NUL) begin
            seq[15:0] = {tail, jse_pkg::CHR_BSLASH};
            return int'(jse_pkg::RUN_LEN_SHORT);
         end
         if (b < jse_pkg::CTRL_LIMIT) begin
            seq = {hex_char(b[3:0]), hex_char(b[7:4]), jse_pkg::CHR_ZERO, jse_pkg::CHR_ZERO,
                   jse_pkg::CHR_LOW_U, jse_pkg::CHR_BSLASH};
            return int'(jse_pkg::RUN_LEN_UNI);
         end
         seq[7:0] = b;
         return int'(jse_pkg::RUN_LEN_PLAIN);
      endfunction

      // Called for every accepted source byte.
      function void note_byte(logic [7:0] b);
         logic [47:0]     seq;
         int              n;
         escape_beat_type beat;
         bytes_seen++;
         if (b == jse_pkg::CHR_NUL) begin
            // The terminator always produces its end transaction, even when halted.
            beat.out_byte = jse_pkg::CHR_NUL;
            beat.is_end   = 1'b1;
            beat.last     = 1'b1;
            beat.length   = jse_pkg::len_type'(out_count);
            owed_q.push_back(beat);
            out_count = '0;
            halted    = 1'b0;
            strings_ended++;
            return;
         end
         if (halted) begin
            return;
         end
         n = expand(b, seq);
         // A run that would reach the capacity is dropped whole and halts the string.
         if (int'(out_count) + n >= int'(capacity)) begin
            halted = 1'b1;
            return;
         end
         for (int k = 0; k < n; k++) begin
            out_count     = out_count + 1'b1;
            beat.out_byte = seq[8*k +: 8];
            beat.is_end   = 1'b0;
            beat.last     = (k == n - 1);
            beat.length   = jse_pkg::len_type'(out_count);
            owed_q.push_back(beat);
         end
      endfunction

      // Called for every accepted response transaction.
      function void check_result(escape_beat_type got);
         escape_beat_type want;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("[%0t] unexpected response: byte=%02h end=%0b last=%0b len=%0d",
                        $time, got.out_byte, got.is_end, got.last, got.length);
            end
            return;
         end
         want = owed_q.pop_front();
         beats_checked++;
         if (got.out_byte !== want.out_byte || got.is_end !== want.is_end ||
             got.last !== want.last || got.length !== want.length) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("[%0t] mismatch: expected byte=%02h end=%0b last=%0b len=%0d",
                        $time, want.out_byte, want.is_end, want.last, want.length);
               $display("[%0t]           actual   byte=%02h end=%0b last=%0b len=%0d",
                        $time, got.out_byte, got.is_end, got.last, got.length);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   jse_req_if req_if ();
   jse_rsp_if rsp_if ();
   jse_csr_if csr_if ();

   json_string_escape u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   escape_scoreboard sb;

   // Percent of cycles in which the sender holds back or the receiver stalls.
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int cap_low        = 65535;
   int cap_high       = 0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Every input is known from time zero.
   initial begin
      req_if.valid    = 1'b0;
      req_if.in_byte  = 8'h00;
      csr_if.valid    = 1'b0;
      csr_if.capacity = jse_pkg::CAPACITY_RESET;
      rsp_if.ready    = 1'b1;
      repeat (RESET_TICKS) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // The receiver decides at each falling edge whether it takes a response next cycle.
   always @(negedge clock) begin
      rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // Transactions are observed at the rising edge, before the block updates its outputs.
   always @(posedge clock) begin
      escape_beat_type beat;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            sb.set_capacity(csr_if.capacity);
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_byte(req_if.in_byte);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            beat.out_byte = rsp_if.out_byte;
            beat.is_end   = rsp_if.is_end;
            beat.last     = rsp_if.last;
            beat.length   = rsp_if.length;
            sb.check_result(beat);
         end
      end
   end

   // Hang detector: any accepted transaction on any channel restarts the count.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Presents one source byte and returns at the falling edge after it was taken.
   // The valid stays high on return so that back-to-back bytes need no gap.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.in_byte = b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Holds the sender back until the block has delivered everything it owes.
   task automatic drain_responses();
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Capacity writes happen only with nothing in flight.
   task automatic write_capacity(input jse_pkg::cap_type value);
      drain_responses();
      repeat (SETTLE) @(negedge clock);
      csr_if.valid    = 1'b1;
      csr_if.capacity = value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
      if (int'(value) < cap_low) cap_low = int'(value);
      if (int'(value) > cap_high) cap_high = int'(value);
   endtask

   // A random non-zero byte, weighted toward text with a fair share of every escape form.
   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) begin
         return 8'($urandom_range(8'h20, 8'h7E));
      end else if (roll < 68) begin
         case ($urandom_range(6))
            0:       return jse_pkg::CHR_QUOTE;
            1:       return jse_pkg::CHR_BSLASH;
            2:       return jse_pkg::CHR_LF;
            3:       return jse_pkg::CHR_CR;
            4:       return jse_pkg::CHR_TAB;
            5:       return jse_pkg::CHR_BS;
            default: return jse_pkg::CHR_FF;
         endcase
      end else if (roll < 82) begin
         return 8'($urandom_range(8'h01, 8'h1F));
      end else if (roll < 94) begin
         return 8'($urandom_range(8'h80, 8'hFF));
      end
      return 8'($urandom_range(8'h01, 8'hFF));
   endfunction

   initial begin
      int               sent;
      int               str_len;
      int               str_idx;
      jse_pkg::cap_type cap;
      sb = new();
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed: every escape form and the ends of the byte range at full capacity.
      write_capacity(jse_pkg::CAPACITY_RESET);
      send_byte(8'h41);              send_byte(jse_pkg::CHR_QUOTE);
      send_byte(jse_pkg::CHR_BSLASH); send_byte(jse_pkg::CHR_LF);
      send_byte(jse_pkg::CHR_CR);     send_byte(jse_pkg::CHR_TAB);
      send_byte(jse_pkg::CHR_BS);     send_byte(jse_pkg::CHR_FF);
      send_byte(8'h01);              send_byte(8'h1F);
      send_byte(8'h20);              send_byte(8'h80);
      send_byte(8'hFF);              send_byte(jse_pkg::CHR_NUL);

      // Small capacity: a six-byte run that does not fit halts the string, later
      // bytes are ignored, and a run that would exactly reach the capacity is dropped.
      write_capacity(16'd4);
      send_byte(8'h61); send_byte(8'h1F); send_byte(8'h62); send_byte(jse_pkg::CHR_NUL);
      send_byte(8'h61); send_byte(8'h62); send_byte(8'h63); send_byte(8'h64);
      send_byte(jse_pkg::CHR_NUL);

      // Capacity one leaves room for nothing but the terminator.
      write_capacity(16'd1);
      send_byte(8'h78); send_byte(jse_pkg::CHR_NUL);

      // Random phases: each idle mode twice, with a different capacity each time.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       cap = jse_pkg::CAPACITY_RESET;
            1:       cap = 16'd1;
            2:       cap = 16'd2;
            3:       cap = jse_pkg::cap_type'($urandom_range(3, 12));
            4:       cap = jse_pkg::cap_type'($urandom_range(13, 60));
            5:       cap = 16'd7;
            6:       cap = jse_pkg::cap_type'($urandom_range(1, 65535));
            default: cap = 16'd40;
         endcase
         write_capacity(cap);
         case (phase % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 50; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 50; end
            default: begin send_idle_pct = 23; rsp_stall_pct = 23; end
         endcase
         sent    = 0;
         str_idx = 0;
         while (sent < PHASE_ITEMS) begin
            str_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            for (int k = 0; k < str_len; k++) begin
               send_byte(pick_byte());
               sent++;
            end
            // Most strings are terminated; a few run on into the next one,
            // or even across a capacity change.
            if ($urandom_range(7) != 0) begin
               send_byte(jse_pkg::CHR_NUL);
               sent++;
            end
            if (str_idx == 1 || $urandom_range(9) == 0) begin
               drain_responses();
            end
            str_idx++;
         end
      end

      req_if.valid  = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      drain_responses();
      repeat (SETTLE) @(posedge clock);

      $display("Run covered %0d source bytes and %0d strings, checking %0d responses,",
               sb.bytes_seen, sb.strings_ended, sb.beats_checked);
      $display("with capacities from %0d to %0d under four sender/receiver idle modes.",
               cap_low, cap_high);
      if (sb.pending() != 0) begin
         $display("%0d expected responses never arrived", sb.pending());
      end
      if (sb.mismatches != 0) begin
         $display("%0d response mismatches", sb.mismatches);
      end
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
